// File: rtl/kmer_hash_table_probe_macros.svh
// assertion macros shared by the k-mer hash table probe rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef KMER_HASH_TABLE_PROBE_MACROS_SVH
`define KMER_HASH_TABLE_PROBE_MACROS_SVH

// condition implies consequence in the same cycle
`define KHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define KHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/khp_pkg.sv
// shared types, codes and constants for the k-mer hash table probe
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package khp_pkg;

    // parameter defaults
    localparam int MAX_LEVEL_DEF = 32;
    localparam int SLOTS_DEF     = 1024;
    localparam int ENTRIES_DEF   = 512;

    // field widths
    localparam int ACTION_W   = 3;
    localparam int LEVEL_W    = 6;
    localparam int KEY_W      = 64;
    localparam int POS_W      = 10;
    localparam int WORD_W     = 10;
    localparam int IVAL_W     = 36;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_LOOKUP_LEVEL = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP_TERM  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WR_HEADER    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WR_SLOT      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WR_ENTRY     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

    // splitmix finalizer constants
    localparam logic [63:0] MIX_C0 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C2 = 64'h94D0_49BB_1331_11EB;

    // hash datapath operations
    localparam logic [2:0] HOP_NONE = 3'd0;
    localparam logic [2:0] HOP_LOAD = 3'd1;
    localparam logic [2:0] HOP_XS30 = 3'd2;
    localparam logic [2:0] HOP_XS27 = 3'd3;
    localparam logic [2:0] HOP_XS31 = 3'd4;
    localparam logic [2:0] HOP_M0   = 3'd5;
    localparam logic [2:0] HOP_M1   = 3'd6;
    localparam logic [2:0] HOP_M2   = 3'd7;

    // response kinds
    localparam logic [1:0] RSP_MISS = 2'd0;
    localparam logic [1:0] RSP_HIT  = 2'd1;
    localparam logic [1:0] RSP_EXH  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [LEVEL_W-1:0]  level;
        logic [KEY_W-1:0]    key;
        logic [POS_W-1:0]    position;
        logic [WORD_W-1:0]   word;
        logic [IVAL_W-1:0]   interval_k;
        logic [IVAL_W-1:0]   interval_l;
        logic [IVAL_W-1:0]   interval_s;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [IVAL_W-1:0] hit_k;
        logic [IVAL_W-1:0] hit_l;
        logic [IVAL_W-1:0] hit_s;
        logic              probe_exhausted;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [IVAL_W-1:0] k;
        logic [IVAL_W-1:0] l;
        logic [IVAL_W-1:0] s;
    } ent_t;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic [2:0] hop;
        logic       mul_sel;
        logic       hdr_rd;
        logic       hdr_cap;
        logic       wr_exec;
        logic       probe_init;
        logic       mod_a;
        logic       mod_b;
        logic       slot_rd;
        logic       ent_rd;
        logic       probe_next;
        logic       rsp_load;
        logic [1:0] rsp_kind;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                lookup_ok;
        logic                wr_ok;
        logic                count_zero;
        logic                slot_empty;
        logic                key_match;
        logic                probe_last;
        logic                rsp_free;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/khp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module khp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/khp_datapath.sv
// datapath: config registers, splitmix hash, table memories, probe state, response register
// depends on khp_pkg and khp_ram
`timescale 1ns / 1ps
`default_nettype none

module khp_datapath #(
    parameter int MAX_LEVEL         = khp_pkg::MAX_LEVEL_DEF,
    parameter int SLOTS_PER_TABLE   = khp_pkg::SLOTS_DEF,
    parameter int ENTRIES_PER_TABLE = khp_pkg::ENTRIES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire khp_pkg::req_t                       req_data,
    input  wire logic                                cfg_valid,
    input  wire logic [khp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [khp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire khp_pkg::cmd_t                       cmd,
    output khp_pkg::sts_t                            sts,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output khp_pkg::rsp_t                            rsp_data
);

    localparam int TABLE_COUNT = MAX_LEVEL + 2;
    localparam int TERMINAL    = MAX_LEVEL + 1;
    localparam int TBL_W       = $clog2(TABLE_COUNT);
    localparam int SLOT_DEPTH  = TABLE_COUNT * SLOTS_PER_TABLE;
    localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
    localparam int ENT_DEPTH   = TABLE_COUNT * ENTRIES_PER_TABLE;
    localparam int ENT_AW      = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int ENT_W       = $bits(khp_pkg::ent_t);
    localparam int HDR_W       = khp_pkg::POS_W + khp_pkg::WORD_W;
    localparam int RECIP_SH    = 20;
    localparam int RECIP       = ((1 << RECIP_SH) + SLOTS_PER_TABLE - 1) / SLOTS_PER_TABLE;
    localparam int MPROD_W     = 31;

    // request and config state
    khp_pkg::req_t                      req_reg;
    logic [TBL_W-1:0]                   table_reg;
    logic                               enable_reg;
    logic [khp_pkg::LEVEL_W-1:0]        min_reg;
    logic [khp_pkg::LEVEL_W-1:0]        max_reg;

    // hash state
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_c;
    logic [63:0] prod;

    // header and probe state
    logic [TABLE_COUNT-1:0]            hdr_vld_reg;
    logic                              hdr_hit_reg;
    logic [khp_pkg::POS_W-1:0]         mask_reg;
    logic [khp_pkg::WORD_W-1:0]        count_reg;
    logic [khp_pkg::POS_W-1:0]         slot_reg;
    logic [khp_pkg::POS_W-1:0]         cnt_reg;
    logic [MPROD_W-1:0]                mprod_reg;
    logic [khp_pkg::POS_W-1:0]         smod_reg;
    logic [MPROD_W-RECIP_SH-1:0]       quot;

    // memory ports
    logic [HDR_W-1:0]                  hdr_rdata;
    logic                              hdr_we;
    logic [khp_pkg::WORD_W-1:0]        slot_rdata;
    logic                              slot_we;
    logic [SLOT_AW-1:0]                slot_waddr;
    logic [SLOT_AW-1:0]                slot_raddr;
    khp_pkg::ent_t                     ent_rdata;
    khp_pkg::ent_t                     ent_wdata;
    logic                              ent_we;
    logic [ENT_AW-1:0]                 ent_waddr;
    logic [ENT_AW-1:0]                 ent_raddr;

    khp_pkg::rsp_t                     rsp_reg;
    logic                              rsp_valid_reg;

    // config writes, taken every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            min_reg    <= 6'd1;
            max_reg    <= 6'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                khp_pkg::CFG_ENABLE:    enable_reg <= cfg_data[0];
                khp_pkg::CFG_MIN_LEVEL: min_reg    <= cfg_data;
                khp_pkg::CFG_MAX_LEVEL: max_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    // request capture and table select
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_data;
            if (req_data.action == khp_pkg::ACT_LOOKUP_TERM)
            begin
                table_reg <= TBL_W'(TERMINAL);
            end
            else
            begin
                table_reg <= req_data.level[TBL_W-1:0];
            end
        end
    end

    // hash multiplier, one 32x32 partial product per cycle
    assign mul_c = cmd.mul_sel ? khp_pkg::MIX_C2 : khp_pkg::MIX_C1;
    assign mul_a = (cmd.hop == khp_pkg::HOP_M2) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (cmd.hop == khp_pkg::HOP_M1) ? mul_c[63:32] : mul_c[31:0];
    assign prod  = mul_a * mul_b;

    // hash sequence steps
    always_ff @(posedge clk)
    begin
        case (cmd.hop)
            khp_pkg::HOP_LOAD: x_reg <= req_reg.key + khp_pkg::MIX_C0;
            khp_pkg::HOP_XS30: x_reg <= x_reg ^ (x_reg >> 30);
            khp_pkg::HOP_XS27: x_reg <= x_reg ^ (x_reg >> 27);
            khp_pkg::HOP_XS31: x_reg <= x_reg ^ (x_reg >> 31);
            khp_pkg::HOP_M0:   acc_reg <= prod;
            khp_pkg::HOP_M1:   acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
            khp_pkg::HOP_M2:   x_reg <= {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
            default:           ;
        endcase
    end

    // header store, valid bits stand in for the zero reset
    assign hdr_we = cmd.wr_exec && (req_reg.action == khp_pkg::ACT_WR_HEADER);

    khp_ram #(
        .WIDTH (HDR_W),
        .DEPTH (TABLE_COUNT)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (hdr_we),
        .waddr (table_reg),
        .wdata ({req_reg.position, req_reg.word}),
        .re    (cmd.hdr_rd),
        .raddr (table_reg),
        .rdata (hdr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_vld_reg <= '0;
        end
        else if (hdr_we)
        begin
            hdr_vld_reg[table_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_rd)
        begin
            hdr_hit_reg <= hdr_vld_reg[table_reg];
        end
        if (cmd.hdr_cap)
        begin
            mask_reg  <= hdr_hit_reg ? hdr_rdata[HDR_W-1:khp_pkg::WORD_W] : '0;
            count_reg <= hdr_hit_reg ? hdr_rdata[khp_pkg::WORD_W-1:0] : '0;
        end
    end

    // slot store
    assign slot_we = cmd.wr_exec && (req_reg.action == khp_pkg::ACT_WR_SLOT)
                     && (17'(req_reg.position) < 17'(SLOTS_PER_TABLE));
    assign slot_waddr = SLOT_AW'(int'(table_reg) * SLOTS_PER_TABLE + int'(req_reg.position));
    assign slot_raddr = SLOT_AW'(int'(table_reg) * SLOTS_PER_TABLE + int'(smod_reg));

    khp_ram #(
        .WIDTH (khp_pkg::WORD_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (req_reg.word),
        .re    (cmd.slot_rd),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // entry store
    assign ent_we = cmd.wr_exec && (req_reg.action == khp_pkg::ACT_WR_ENTRY)
                    && (17'(req_reg.position) < 17'(ENTRIES_PER_TABLE));
    assign ent_waddr = ENT_AW'(int'(table_reg) * ENTRIES_PER_TABLE + int'(req_reg.position));
    assign ent_raddr = ENT_AW'(int'(table_reg) * ENTRIES_PER_TABLE + int'(slot_rdata) - 1);
    assign ent_wdata = '{key: req_reg.key, k: req_reg.interval_k,
                         l: req_reg.interval_l, s: req_reg.interval_s};

    khp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENT_DEPTH)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (cmd.ent_rd),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // probe slot, counter and slot wrap by reciprocal multiply
    assign quot = mprod_reg[MPROD_W-1:RECIP_SH];

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            slot_reg <= x_reg[khp_pkg::POS_W-1:0] & mask_reg;
            cnt_reg  <= '0;
        end
        else if (cmd.probe_next)
        begin
            slot_reg <= (slot_reg + 1'b1) & mask_reg;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.mod_a)
        begin
            mprod_reg <= MPROD_W'(int'(slot_reg) * RECIP);
        end
        if (cmd.mod_b)
        begin
            smod_reg <= khp_pkg::POS_W'(int'(slot_reg) - int'(quot) * SLOTS_PER_TABLE);
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_reg <= '0;
            case (cmd.rsp_kind)
                khp_pkg::RSP_HIT:
                begin
                    rsp_reg.found <= 1'b1;
                    rsp_reg.hit_k <= ent_rdata.k;
                    rsp_reg.hit_l <= ent_rdata.l;
                    rsp_reg.hit_s <= ent_rdata.s;
                end
                khp_pkg::RSP_EXH: rsp_reg.probe_exhausted <= 1'b1;
                default:          ;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // status to the controller
    always_comb
    begin
        sts.action    = req_reg.action;
        sts.lookup_ok = enable_reg
                        && ((req_reg.action == khp_pkg::ACT_LOOKUP_TERM)
                            || ((req_reg.level >= min_reg) && (req_reg.level <= max_reg)
                                && (7'(req_reg.level) <= 7'(MAX_LEVEL))));
        sts.wr_ok      = 7'(req_reg.level) < 7'(TABLE_COUNT);
        sts.count_zero = (count_reg == '0);
        sts.slot_empty = (slot_rdata == '0)
                         || (int'(slot_rdata) - 1 >= ENTRIES_PER_TABLE);
        sts.key_match  = (ent_rdata.key == req_reg.key);
        sts.probe_last = (cnt_reg == mask_reg);
        sts.rsp_free   = !rsp_valid_reg || !rsp_stall;
    end

endmodule

`default_nettype wire

// File: rtl/khp_ctrl.sv
// controller state machine: request intake, hash sequencing, probe loop, response hand-off
// depends on khp_pkg and kmer_hash_table_probe_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_hash_table_probe_macros.svh"

module khp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output khp_pkg::cmd_t      cmd,
    input  wire khp_pkg::sts_t sts
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_HASH     = 4'd2;
    localparam logic [3:0] S_PSTART   = 4'd3;
    localparam logic [3:0] S_MOD_A    = 4'd4;
    localparam logic [3:0] S_MOD_B    = 4'd5;
    localparam logic [3:0] S_SLOT_RD  = 4'd6;
    localparam logic [3:0] S_SLOT_CHK = 4'd7;
    localparam logic [3:0] S_ENT_CHK  = 4'd8;
    localparam logic [3:0] S_RESP     = 4'd9;

    localparam logic [3:0] HASH_LAST  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            kind_reg  <= khp_pkg::RSP_MISS;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                step_next = '0;
                if (sts.action == khp_pkg::ACT_LOOKUP_LEVEL
                    || sts.action == khp_pkg::ACT_LOOKUP_TERM)
                begin
                    if (sts.lookup_ok)
                    begin
                        cmd.hdr_rd = 1'b1;
                        state_next = S_HASH;
                    end
                    else
                    begin
                        kind_next  = khp_pkg::RSP_MISS;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cmd.wr_exec = sts.wr_ok;
                    state_next  = S_IDLE;
                end
            end
            S_HASH:
            begin
                cmd.hdr_cap = (step_reg == '0);
                cmd.mul_sel = (step_reg > 4'd5);
                case (step_reg)
                    4'd0:    cmd.hop = khp_pkg::HOP_LOAD;
                    4'd1:    cmd.hop = khp_pkg::HOP_XS30;
                    4'd2:    cmd.hop = khp_pkg::HOP_M0;
                    4'd3:    cmd.hop = khp_pkg::HOP_M1;
                    4'd4:    cmd.hop = khp_pkg::HOP_M2;
                    4'd5:    cmd.hop = khp_pkg::HOP_XS27;
                    4'd6:    cmd.hop = khp_pkg::HOP_M0;
                    4'd7:    cmd.hop = khp_pkg::HOP_M1;
                    4'd8:    cmd.hop = khp_pkg::HOP_M2;
                    4'd9:    cmd.hop = khp_pkg::HOP_XS31;
                    default: cmd.hop = khp_pkg::HOP_NONE;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == HASH_LAST)
                begin
                    state_next = S_PSTART;
                end
            end
            S_PSTART:
            begin
                if (sts.count_zero)
                begin
                    kind_next  = khp_pkg::RSP_MISS;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_MOD_A;
                end
            end
            S_MOD_A:
            begin
                cmd.mod_a  = 1'b1;
                state_next = S_MOD_B;
            end
            S_MOD_B:
            begin
                cmd.mod_b  = 1'b1;
                state_next = S_SLOT_RD;
            end
            S_SLOT_RD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                if (sts.slot_empty)
                begin
                    kind_next  = khp_pkg::RSP_MISS;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_ENT_CHK;
                end
            end
            S_ENT_CHK:
            begin
                if (sts.key_match)
                begin
                    kind_next  = khp_pkg::RSP_HIT;
                    state_next = S_RESP;
                end
                else if (sts.probe_last)
                begin
                    kind_next  = khp_pkg::RSP_EXH;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_MOD_A;
                end
            end
            S_RESP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.rsp_load = 1'b1;
                    cmd.rsp_kind = kind_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    `KHP_ASSERT_NEXT(a_accept_dispatch, req_valid && !req_stall, state_reg == S_DISPATCH, "accepted request not dispatched")
    `KHP_ASSERT_NOW(a_load_in_resp, cmd.rsp_load, state_reg == S_RESP && sts.rsp_free, "response loaded outside response state")
    `KHP_ASSERT_NOW(a_hash_step_range, state_reg == S_HASH, step_reg <= HASH_LAST, "hash step out of range")
    `KHP_ASSERT_NEXT(a_hit_needs_entry, state_reg == S_SLOT_CHK && !sts.slot_empty, state_reg == S_ENT_CHK, "entry check skipped")

endmodule

`default_nettype wire

// File: rtl/kmer_hash_table_probe.sv
// K-mer hash table probe. Writes (header, slot, entry) give no response. A lookup
// that is disabled or out of range answers with a miss without hashing; an empty
// table answers with a miss after the hash; otherwise the answer comes after the
// hash and a probe over successive slots that ends at an empty slot, a key match
// or the last slot. A stall on the response side holds the answer back. The hash
// is a 10-step sequence over one shared 32x32 multiplier, and each probe is a
// slot-wrap multiply, a slot memory read and an entry memory read in turn. One
// request is in flight at a time; a finished response waits in its own register
// so the next request can be accepted. Table headers reset to zero through valid
// bits, so no clearing pass is needed. Configuration writes are always ready.
// depends on khp_pkg, khp_ctrl, khp_datapath
`timescale 1ns / 1ps
`default_nettype none

module kmer_hash_table_probe #(
    parameter int MAX_LEVEL         = khp_pkg::MAX_LEVEL_DEF,
    parameter int SLOTS_PER_TABLE   = khp_pkg::SLOTS_DEF,
    parameter int ENTRIES_PER_TABLE = khp_pkg::ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire khp_pkg::req_t                  req_data,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output khp_pkg::rsp_t                       rsp_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [khp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [khp_pkg::CFG_DATA_W-1:0] cfg_data
);

    khp_pkg::cmd_t cmd;
    khp_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    khp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    khp_datapath #(
        .MAX_LEVEL         (MAX_LEVEL),
        .SLOTS_PER_TABLE   (SLOTS_PER_TABLE),
        .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire
